>>> rtl/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types, constants and helpers of the task slot scheduler.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int TASK_SLOTS = 8;
  localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int KIND_W     = 3;
  localparam int DELAY_W    = 32;
  localparam int ID_W       = 3;

  typedef logic [SLOT_W-1:0] slot_t;

  localparam slot_t SLOT_LAST = slot_t'(TASK_SLOTS - 1);

  typedef enum logic [1:0] {
    ST_FREE     = 2'd0,
    ST_READY    = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_SLEEPING = 2'd3
  } slot_state_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE   = 3'd0,
    KIND_SLEEP    = 3'd1,
    KIND_TICK     = 3'd2,
    KIND_SCHEDULE = 3'd3,
    KIND_START    = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_DECODE,
    CS_CREATE,
    CS_SLEEP,
    CS_TICK,
    CS_TICK_TAIL,
    CS_SCHED,
    CS_START,
    CS_DEMOTE,
    CS_PROMOTE,
    CS_FINISH
  } ctrl_state_t;

  typedef enum logic [1:0] {
    SEL_PTR,
    SEL_RUN,
    SEL_PREV
  } sel_t;

  typedef struct packed {
    logic        capture;
    sel_t        sel;
    logic        ptr_zero;
    logic        ptr_base;
    logic        ptr_idx;
    logic        ptr_inc;
    logic        steps_clr;
    logic        st_wr;
    slot_state_t st_val;
    logic        cnt_wr_zero;
    logic        cnt_wr_delay;
    logic        tick_step;
    logic        tick_tail;
    logic        run_set;
    logic        res_clr;
    logic        res_fail;
    logic        res_id;
    logic        out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              idx_oob;
    slot_state_t       st_rd;
    logic              run_valid;
    logic              run_match;
    logic              ptr_last;
    logic              steps_last;
    logic              out_free;
  } dp_stat_t;

  function automatic logic [ID_W-1:0] slot_to_id(input slot_t s);
    logic [SLOT_W+ID_W-1:0] w;
    w = {{ID_W{1'b0}}, s};
    return w[ID_W-1:0];
  endfunction

  function automatic slot_t id_to_slot(input logic [ID_W-1:0] id);
    logic [SLOT_W+ID_W-1:0] w;
    w = {{SLOT_W{1'b0}}, id};
    return w[SLOT_W-1:0];
  endfunction

  function automatic slot_t slot_next(input slot_t s);
    return (s == SLOT_LAST) ? slot_t'(0) : slot_t'(s + 1'b1);
  endfunction

endpackage

>>> rtl/tss_ram.sv
// ----------------------------------------------------------------------------
// tss_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tss_datapath.sv
// ----------------------------------------------------------------------------
// tss_datapath
// Slot table, sleep count memory, running index, scan pointer and result
// registers of the task slot scheduler.
// ----------------------------------------------------------------------------
module tss_datapath
  import tss_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [KIND_W-1:0]   kind,
  input  logic [DELAY_W-1:0]  delay_ticks,
  input  logic [ID_W-1:0]     task_index,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                status,
  output logic [ID_W-1:0]     task_id,
  output logic                resched
);

  slot_state_t         slot_state [TASK_SLOTS];
  slot_t               running_index;
  logic                running_valid;
  slot_t               ptr;
  slot_t               steps;
  slot_t               tick_prev;
  logic                tick_live;
  logic [KIND_W-1:0]   kind_q;
  logic [DELAY_W-1:0]  delay_q;
  logic [ID_W-1:0]     idx_q;
  logic                res_status;
  logic [ID_W-1:0]     res_id;
  logic                res_resched;

  slot_t               sel_addr;
  slot_state_t         st_rd;
  logic                ram_we;
  slot_t               ram_waddr;
  logic [DELAY_W-1:0]  ram_wdata;
  logic [DELAY_W-1:0]  ram_rdata;
  logic [DELAY_W-1:0]  cnt_dec;
  logic                tick_proc;
  logic                tick_sleeping;
  logic                tick_wake;

  always_comb begin
    unique case (cmd.sel)
      SEL_PTR:  sel_addr = ptr;
      SEL_RUN:  sel_addr = running_index;
      SEL_PREV: sel_addr = tick_prev;
      default:  sel_addr = ptr;
    endcase
  end

  assign st_rd         = slot_state[sel_addr];
  assign cnt_dec       = ram_rdata - 1'b1;
  assign tick_proc     = (cmd.tick_step | cmd.tick_tail) & tick_live;
  assign tick_sleeping = tick_proc & (st_rd == ST_SLEEPING);
  assign tick_wake     = tick_sleeping & (cnt_dec == '0);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = '0;
    if (tick_sleeping) begin
      ram_we    = 1'b1;
      ram_waddr = tick_prev;
      ram_wdata = cnt_dec;
    end else if (cmd.cnt_wr_delay) begin
      ram_we    = 1'b1;
      ram_waddr = running_index;
      ram_wdata = delay_q;
    end else if (cmd.cnt_wr_zero) begin
      ram_we    = 1'b1;
      ram_waddr = ptr;
      ram_wdata = '0;
    end
  end

  tss_ram #(
    .WIDTH (DELAY_W),
    .DEPTH (TASK_SLOTS)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        slot_state[i] <= ST_FREE;
      end
      running_index <= '0;
      running_valid <= 1'b0;
      tick_live     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (tick_wake) begin
        slot_state[tick_prev] <= ST_READY;
      end else if (cmd.st_wr) begin
        slot_state[sel_addr] <= cmd.st_val;
      end
      if (cmd.run_set) begin
        running_index <= ptr;
        running_valid <= 1'b1;
      end
      if (cmd.tick_step) begin
        tick_live <= 1'b1;
      end else begin
        tick_live <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q  <= kind;
      delay_q <= delay_ticks;
      idx_q   <= task_index;
    end
    if (cmd.ptr_zero) begin
      ptr <= '0;
    end else if (cmd.ptr_base) begin
      ptr <= running_valid ? slot_next(running_index) : slot_t'(0);
    end else if (cmd.ptr_idx) begin
      ptr <= id_to_slot(idx_q);
    end else if (cmd.ptr_inc || cmd.tick_step) begin
      ptr <= slot_next(ptr);
    end
    if (cmd.steps_clr) begin
      steps <= '0;
    end else if (cmd.ptr_inc) begin
      steps <= slot_t'(steps + 1'b1);
    end
    if (cmd.tick_step) begin
      tick_prev <= ptr;
    end
    if (cmd.res_clr) begin
      res_status  <= 1'b0;
      res_id      <= '0;
      res_resched <= 1'b0;
    end else begin
      if (cmd.res_fail) begin
        res_status <= 1'b1;
      end
      if (cmd.res_id) begin
        res_id <= slot_to_id(ptr);
      end
      if (tick_wake) begin
        res_resched <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      status  <= res_status;
      task_id <= res_id;
      resched <= res_resched;
    end
  end

  assign stat.kind       = kind_q;
  assign stat.idx_oob    = (32'(idx_q) >= TASK_SLOTS);
  assign stat.st_rd      = st_rd;
  assign stat.run_valid  = running_valid;
  assign stat.run_match  = (running_index == ptr);
  assign stat.ptr_last   = (ptr == SLOT_LAST);
  assign stat.steps_last = (steps == SLOT_LAST);
  assign stat.out_free   = ~out_valid | out_ready;

endmodule

>>> rtl/tss_ctrl.sv
// ----------------------------------------------------------------------------
// tss_ctrl
// Sequencer of the task slot scheduler: decodes the event and steps the
// datapath through its slot scans.
// ----------------------------------------------------------------------------
module tss_ctrl
  import tss_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      CS_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = CS_DECODE;
        end
      end
      CS_DECODE: begin
        cmd.res_clr = 1'b1;
        case (stat.kind)
          KIND_CREATE: begin
            cmd.ptr_zero = 1'b1;
            state_next   = CS_CREATE;
          end
          KIND_SLEEP: begin
            state_next = CS_SLEEP;
          end
          KIND_TICK: begin
            cmd.ptr_zero = 1'b1;
            state_next   = CS_TICK;
          end
          KIND_SCHEDULE: begin
            cmd.ptr_base  = 1'b1;
            cmd.steps_clr = 1'b1;
            state_next    = CS_SCHED;
          end
          KIND_START: begin
            cmd.ptr_idx = 1'b1;
            state_next  = CS_START;
          end
          default: begin
            state_next = CS_FINISH;
          end
        endcase
      end
      CS_CREATE: begin
        cmd.sel = SEL_PTR;
        if (stat.st_rd == ST_FREE) begin
          cmd.st_wr       = 1'b1;
          cmd.st_val      = ST_READY;
          cmd.cnt_wr_zero = 1'b1;
          cmd.res_id      = 1'b1;
          state_next      = CS_FINISH;
        end else if (stat.ptr_last) begin
          cmd.res_fail = 1'b1;
          state_next   = CS_FINISH;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      CS_SLEEP: begin
        cmd.sel = SEL_RUN;
        if (stat.run_valid && stat.st_rd == ST_RUNNING) begin
          cmd.st_wr        = 1'b1;
          cmd.st_val       = ST_SLEEPING;
          cmd.cnt_wr_delay = 1'b1;
        end else begin
          cmd.res_fail = 1'b1;
        end
        state_next = CS_FINISH;
      end
      CS_TICK: begin
        cmd.sel       = SEL_PREV;
        cmd.tick_step = 1'b1;
        if (stat.ptr_last) begin
          state_next = CS_TICK_TAIL;
        end
      end
      CS_TICK_TAIL: begin
        cmd.sel       = SEL_PREV;
        cmd.tick_tail = 1'b1;
        state_next    = CS_FINISH;
      end
      CS_SCHED: begin
        cmd.sel = SEL_PTR;
        if (stat.st_rd == ST_READY) begin
          state_next = CS_DEMOTE;
        end else if (stat.steps_last) begin
          cmd.res_fail = 1'b1;
          state_next   = CS_FINISH;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      CS_START: begin
        cmd.sel = SEL_PTR;
        if (stat.idx_oob) begin
          cmd.res_fail = 1'b1;
          state_next   = CS_FINISH;
        end else if (stat.st_rd == ST_RUNNING && stat.run_valid && stat.run_match) begin
          cmd.res_id = 1'b1;
          state_next = CS_FINISH;
        end else if (stat.st_rd == ST_READY) begin
          state_next = CS_DEMOTE;
        end else begin
          cmd.res_fail = 1'b1;
          state_next   = CS_FINISH;
        end
      end
      CS_DEMOTE: begin
        cmd.sel = SEL_RUN;
        if (stat.run_valid && stat.st_rd == ST_RUNNING) begin
          cmd.st_wr  = 1'b1;
          cmd.st_val = ST_READY;
        end
        state_next = CS_PROMOTE;
      end
      CS_PROMOTE: begin
        cmd.sel     = SEL_PTR;
        cmd.st_wr   = 1'b1;
        cmd.st_val  = ST_RUNNING;
        cmd.run_set = 1'b1;
        cmd.res_id  = 1'b1;
        state_next  = CS_FINISH;
      end
      CS_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = CS_IDLE;
        end
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/task_slot_scheduler_top.sv
// ----------------------------------------------------------------------------
// task_slot_scheduler_top
// Round-robin task slot scheduler with sleep counts: create, sleep, tick,
// schedule and start events, one result per event.
// ----------------------------------------------------------------------------
// One event is taken at a time and yields one result. The slot table is
// visited one slot per cycle by the sequencer. The sleep count memory has a
// registered read, so the tick scan runs one slot behind its read.
// A new event is accepted in the cycle after a result is loaded, even while
// that result still waits at the output register.
module task_slot_scheduler_top
  import tss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KIND_W-1:0]  kind,
  input  logic [DELAY_W-1:0] delay_ticks,
  input  logic [ID_W-1:0]    task_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               status,
  output logic [ID_W-1:0]    task_id,
  output logic               resched
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tss_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .kind        (kind),
    .delay_ticks (delay_ticks),
    .task_index  (task_index),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .task_id     (task_id),
    .resched     (resched)
  );

endmodule

>>> dv/task_slot_scheduler_checker.sv
// ----------------------------------------------------------------------------
// task_slot_scheduler_checker
// Watches both channels of the task slot scheduler and keeps its own copy of
// the slot table, sleep counts and running slot. Each event taken in is
// applied to that copy to work out its result. Each result sent out is
// compared field by field with the oldest outstanding one. Mismatches,
// unexpected results and the number of results still owed go to the top.
// ----------------------------------------------------------------------------
module task_slot_scheduler_checker
  import tss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [KIND_W-1:0]  kind,
  input  logic [DELAY_W-1:0] delay_ticks,
  input  logic [ID_W-1:0]    task_index,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               status,
  input  logic [ID_W-1:0]    task_id,
  input  logic               resched,
  output int                 mismatches,
  output int                 pending,
  output int                 checked,
  output int                 wakeups,
  output int                 refusals
);

  typedef struct packed {
    logic            status;
    logic [ID_W-1:0] task_id;
    logic            resched;
  } outcome_t;

  slot_state_t        slot_st   [TASK_SLOTS];
  logic [DELAY_W-1:0] sleep_cnt [TASK_SLOTS];
  int unsigned        run_slot;
  bit                 run_ok;
  outcome_t           owed_outcomes [$];

  initial begin
    mismatches = 0;
    pending    = 0;
    checked    = 0;
    wakeups    = 0;
    refusals   = 0;
  end

  function automatic void note_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // old slot goes back to ready only if it is still running
  function automatic void hand_cpu_to(input int unsigned nxt);
    if (run_ok && run_slot < TASK_SLOTS && slot_st[run_slot] == ST_RUNNING)
      slot_st[run_slot] = ST_READY;
    slot_st[nxt] = ST_RUNNING;
    run_slot     = nxt;
    run_ok       = 1'b1;
  endfunction

  function automatic outcome_t apply_event(input logic [KIND_W-1:0]  k,
                                           input logic [DELAY_W-1:0] d,
                                           input logic [ID_W-1:0]    ti);
    outcome_t    r;
    int unsigned start_at;
    int unsigned j;
    r = '0;
    case (k)
      KIND_CREATE: begin
        r.status = 1'b1;
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (slot_st[i] == ST_FREE) begin
            slot_st[i]   = ST_READY;
            sleep_cnt[i] = '0;
            r.status     = 1'b0;
            r.task_id    = ID_W'(i);
            break;
          end
        end
      end
      KIND_SLEEP: begin
        if (run_ok && run_slot < TASK_SLOTS && slot_st[run_slot] == ST_RUNNING) begin
          sleep_cnt[run_slot] = d;
          slot_st[run_slot]   = ST_SLEEPING;
        end else begin
          r.status = 1'b1;
        end
      end
      KIND_TICK: begin
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (slot_st[i] == ST_SLEEPING) begin
            sleep_cnt[i] = sleep_cnt[i] - 1'b1;
            if (sleep_cnt[i] == '0) begin
              slot_st[i] = ST_READY;
              r.resched  = 1'b1;
            end
          end
        end
      end
      KIND_SCHEDULE: begin
        start_at = run_ok ? run_slot + 1 : 0;
        r.status = 1'b1;
        for (int i = 0; i < TASK_SLOTS; i++) begin
          j = (start_at + i) % TASK_SLOTS;
          if (slot_st[j] == ST_READY) begin
            hand_cpu_to(j);
            r.status  = 1'b0;
            r.task_id = ID_W'(j);
            break;
          end
        end
      end
      KIND_START: begin
        if (int'(ti) >= TASK_SLOTS) begin
          r.status = 1'b1;
        end else if (slot_st[ti] == ST_RUNNING && run_ok && run_slot == ti) begin
          r.task_id = ti;
        end else if (slot_st[ti] == ST_READY) begin
          hand_cpu_to(ti);
          r.task_id = ti;
        end else begin
          r.status = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    outcome_t got;
    if (rst) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        slot_st[i]   = ST_FREE;
        sleep_cnt[i] = '0;
      end
      run_slot = 0;
      run_ok   = 1'b0;
      owed_outcomes.delete();
      pending <= 0;
    end else begin
      if (in_valid && in_ready)
        owed_outcomes.push_back(apply_event(kind, delay_ticks, task_index));
      if (out_valid && out_ready) begin
        got = '{status: status, task_id: task_id, resched: resched};
        if (owed_outcomes.size() == 0) begin
          note_error($sformatf("unexpected result: status %0b task_id %0d resched %0b",
                               got.status, got.task_id, got.resched));
        end else begin
          want = owed_outcomes.pop_front();
          checked++;
          if (want.resched) wakeups++;
          if (want.status) refusals++;
          if (got.status !== want.status || got.task_id !== want.task_id ||
              got.resched !== want.resched)
            note_error($sformatf({"result %0d mismatch: expected status %0b task_id %0d ",
                                  "resched %0b, got status %0b task_id %0d resched %0b"},
                                 checked, want.status, want.task_id, want.resched,
                                 got.status, got.task_id, got.resched));
        end
      end
      pending <= owed_outcomes.size();
    end
  end

endmodule

>>> dv/task_slot_scheduler_top_test.sv
// ----------------------------------------------------------------------------
// task_slot_scheduler_top_test
// Drives the task slot scheduler with a directed opening (empty table,
// refused requests, switches, zero sleeps, wakeups, unused
// kinds, full table) and then random event mixes under three idle patterns,
// with long output hold-offs and full drains. Checking is done by the
// checker instance; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module task_slot_scheduler_top_test;
  import tss_pkg::*;

  localparam int RANDOM_PER_PHASE = 375;
  localparam int HOLD_CYCLES      = 150;
  localparam int STALL_LIMIT      = 4000;
  localparam int TAIL_CYCLES      = 40;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic [KIND_W-1:0]  kind        = '0;
  logic [DELAY_W-1:0] delay_ticks = '0;
  logic [ID_W-1:0]    task_index  = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic               status;
  logic [ID_W-1:0]    task_id;
  logic               resched;

  int          mismatches;
  int          pending;
  int          checked;
  int          wakeups;
  int          refusals;
  int          sent          = 0;
  int unsigned tx_idle_pct   = 0;
  int unsigned rx_idle_pct   = 0;
  bit          hold_pending  = 1'b0;
  int unsigned quiet_cycles  = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task_slot_scheduler_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .delay_ticks (delay_ticks),
    .task_index  (task_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .task_id     (task_id),
    .resched     (resched)
  );

  task_slot_scheduler_checker chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .delay_ticks (delay_ticks),
    .task_index  (task_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .task_id     (task_id),
    .resched     (resched),
    .mismatches  (mismatches),
    .pending     (pending),
    .checked     (checked),
    .wakeups     (wakeups),
    .refusals    (refusals)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results owed", STALL_LIMIT, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver side
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_event(input logic [KIND_W-1:0]  k,
                            input logic [DELAY_W-1:0] d,
                            input logic [ID_W-1:0]    ti);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    delay_ticks <= d;
    task_index  <= ti;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_random_event();
    int unsigned        roll;
    logic [KIND_W-1:0]  k;
    logic [DELAY_W-1:0] d;
    roll = $urandom_range(0, 99);
    if (roll < 8)       k = KIND_CREATE;
    else if (roll < 25) k = KIND_SLEEP;
    else if (roll < 55) k = KIND_TICK;
    else if (roll < 75) k = KIND_SCHEDULE;
    else if (roll < 95) k = KIND_START;
    else                k = KIND_W'($urandom_range(KIND_START + 1, 2**KIND_W - 1));
    // short sleeps keep slots cycling; other kinds carry full-width noise
    if (k == KIND_SLEEP)
      d = ($urandom_range(0, 99) < 85) ? DELAY_W'($urandom_range(1, 8))
                                       : DELAY_W'($urandom_range(9, 60));
    else
      d = $urandom();
    send_event(k, d, ID_W'($urandom_range(0, 2**ID_W - 1)));
  endtask

  initial begin
    tx_idle_pct = 27;
    rx_idle_pct = 83;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_event(KIND_SCHEDULE, '0, '0);
    send_event(KIND_SLEEP, 32'd5, '0);
    send_event(KIND_START, '0, '1);
    send_event(KIND_TICK, '0, '0);
    repeat (3) send_event(KIND_CREATE, '0, '0);
    send_event(KIND_SCHEDULE, '0, '0);
    send_event(KIND_START, '0, ID_W'(0));
    send_event(KIND_START, '0, ID_W'(2));
    send_event(KIND_SLEEP, 32'd1, '0);
    send_event(KIND_SLEEP, 32'd3, '0);
    send_event(KIND_SCHEDULE, '0, '0);
    send_event(KIND_SLEEP, '0, '0);
    send_event(KIND_TICK, '1, '0);
    send_event(KIND_START, '0, ID_W'(0));
    send_event(KIND_SCHEDULE, '0, '0);
    for (int u = KIND_START + 1; u < 2**KIND_W; u++)
      send_event(KIND_W'(u), '1, '1);
    repeat (6) send_event(KIND_CREATE, '0, '0);
    wait_for_results();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 27;
          rx_idle_pct = 83;
        end
        1: begin
          tx_idle_pct = 83;
          rx_idle_pct = 27;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n == 40) hold_pending = 1'b1;
        send_random_event();
      end
      wait_for_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d events over three idle patterns with output hold-offs and drains;",
             sent);
    $display("checked %0d results, %0d ticks woke tasks, %0d requests refused",
             checked, wakeups, refusals);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
